// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the echo ranger blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define UER_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define UER_NEVER(label, cond, msg) \
	`UER_ASSERT(label, !(cond), msg)

`endif

// File: design/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// types, widths and codes shared by the ultrasonic echo ranger
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

	localparam int CHANNELS_DEF   = 4;
	localparam int COUNT_BITS_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int CHAN_W   = 2;
	localparam int SENSOR_W = 2;
	localparam int FULL_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int DIV_W    = FULL_W + 4;
	localparam int DIST_W   = 17;
	localparam int LEVEL_W  = 8;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hffff;
	localparam logic [FULL_W-1:0]   FULL_RESET   = 16'd100;

	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ECHO    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd2;

	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_TRIGGER = 1'b1;

	localparam logic REG_COUNT_PERIOD = 1'b0;
	localparam logic REG_FULL         = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAN_W-1:0] channel;
	} in_beat_t;

	typedef struct packed {
		logic                kind;
		logic [SENSOR_W-1:0] sensor;
		logic [DIST_W-1:0]   distance_hundredths;
		logic [LEVEL_W-1:0]  level;
	} out_beat_t;

	typedef struct packed {
		logic                kind;
		logic [SENSOR_W-1:0] sensor;
	} job_hdr_t;

endpackage

`default_nettype wire

// File: design/uer_front.sv
// ----------------------------------------------------------------------------
// uer_front
// tick counter, per-channel armed flags and trigger round robin
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_front #(
	parameter int CHANNELS   = uer_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire uer_pkg::in_beat_t             item,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [uer_pkg::PERIOD_W-1:0]  count_period,
	input  wire logic                          q_full,
	output logic                               push,
	output uer_pkg::job_hdr_t                  push_hdr,
	output logic [COUNT_BITS-1:0]              push_count
);

	localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [COUNT_BITS-1:0] tick_q;
	logic [CHANNELS-1:0]   armed_q;
	logic [SEL_W-1:0]      next_q;

	logic [CHANNELS-1:0] hit;
	logic                chan_ok;
	logic                armed_hit;
	logic                is_tick;
	logic                is_echo;
	logic                is_trig;
	logic                needs_push;
	logic                in_fire;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i] = (32'(item.channel) == i);
		end
	end

	assign chan_ok    = |hit;
	assign armed_hit  = |(armed_q & hit);
	assign is_tick    = (item.mode == uer_pkg::MODE_TICK);
	assign is_echo    = (item.mode == uer_pkg::MODE_ECHO);
	assign is_trig    = (item.mode == uer_pkg::MODE_TRIGGER);
	assign needs_push = is_trig | (is_echo & armed_hit);
	assign item_ready = !q_full | !needs_push;
	assign in_fire    = item_valid & item_ready;

	assign push            = in_fire & needs_push;
	assign push_hdr.kind   = is_trig ? uer_pkg::KIND_TRIGGER : uer_pkg::KIND_MEASURE;
	assign push_hdr.sensor = is_trig ? uer_pkg::SENSOR_W'(next_q) : item.channel;
	assign push_count      = tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			armed_q <= '0;
			next_q  <= '0;
		end else if (in_fire) begin
			if (is_tick) begin
				if (32'(tick_q) >= 32'(count_period)) begin
					tick_q <= '0;
				end else begin
					tick_q <= tick_q + COUNT_BITS'(1);
				end
			end
			if (is_echo && chan_ok) begin
				if (armed_hit) begin
					armed_q <= armed_q & ~hit;
				end else begin
					tick_q  <= '0;
					armed_q <= armed_q | hit;
				end
			end
			if (is_trig) begin
				if (next_q == SEL_W'(CHANNELS - 1)) begin
					next_q <= '0;
				end else begin
					next_q <= next_q + SEL_W'(1);
				end
			end
		end
	end

	// an arming edge restarts the shared counter
	`UER_ASSERT(a_arm_clears, (in_fire && is_echo && chan_ok && !armed_hit) |=> (tick_q == '0), "arming edge left counter running")

endmodule

`default_nettype wire

// File: design/uer_queue.sv
// ----------------------------------------------------------------------------
// uer_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_queue #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire uer_pkg::job_hdr_t     push_hdr,
	input  wire logic [COUNT_BITS-1:0] push_count,
	input  wire logic                  pop,
	output uer_pkg::job_hdr_t          pop_hdr,
	output logic [COUNT_BITS-1:0]      pop_count,
	output logic                       empty,
	output logic                       full
);

	localparam int DEPTH  = uer_pkg::QUEUE_DEPTH;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	uer_pkg::job_hdr_t     hdr_q [DEPTH];
	logic [COUNT_BITS-1:0] cnt_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [FILL_W-1:0]     fill_q;

	assign empty     = (fill_q == '0);
	assign full      = (fill_q == FILL_W'(DEPTH));
	assign pop_hdr   = hdr_q[rd_ptr_q];
	assign pop_count = cnt_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			hdr_q[wr_ptr_q] <= push_hdr;
			cnt_q[wr_ptr_q] <= push_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	`UER_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
	`UER_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

`default_nettype wire

// File: design/uer_back.sv
// ----------------------------------------------------------------------------
// uer_back
// distance by reciprocal multiply, fill level by bit-serial division, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_back #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	input  wire uer_pkg::job_hdr_t            q_hdr,
	input  wire logic [COUNT_BITS-1:0]        q_count,
	output logic                              pop,
	input  wire logic [uer_pkg::FULL_W-1:0]   full_hundredths,
	output uer_pkg::out_beat_t                result,
	output logic                              result_valid,
	input  wire logic                         result_ready
);

	localparam int SCALED_BITS = COUNT_BITS + 5;
	localparam int STEP_W      = $clog2(SCALED_BITS);
	localparam int DIST_W      = uer_pkg::DIST_W;
	localparam int LEVEL_W     = uer_pkg::LEVEL_W;
	localparam int DIV_W       = uer_pkg::DIV_W;

	// divide by ten through the reciprocal, exact below the saturation limit
	localparam int DX_W   = 21;
	localparam int DM_S   = DX_W + 4;
	localparam int DW_W   = (SCALED_BITS > DX_W) ? SCALED_BITS : DX_W;
	localparam int PROD_W = 2 * DX_W + 1;
	localparam logic [DX_W:0]     DM         = (DX_W + 1)'(((2 ** DM_S) + 9) / 10);
	localparam logic [DW_W-1:0]   DIST_LIMIT = DW_W'(10 * (2 ** DIST_W));

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

	back_state_t state_q;

	logic [STEP_W-1:0]          step_q;
	logic [SCALED_BITS-1:0]     dvd_q;
	logic [DIV_W-1:0]           div_q;
	logic [DIST_W-1:0]          dq_q;
	logic                       dovf_q;
	logic [DIV_W-1:0]           lrem_q;
	logic [LEVEL_W-1:0]         lq_q;
	logic                       lovf_q;
	logic                       kind_q;
	logic [uer_pkg::SENSOR_W-1:0] sensor_q;

	logic [SCALED_BITS-1:0] scaled;
	logic                   dbit_in;
	logic [DW_W-1:0]        dvd_w;
	logic [PROD_W-1:0]      dprod;
	logic                   dsat;
	logic [DIV_W:0]         lr;
	logic                   lge;

	assign pop          = (state_q == B_IDLE) && !q_empty;
	assign result_valid = (state_q == B_OUT);

	assign scaled  = (SCALED_BITS'(q_count) << 4) + SCALED_BITS'(q_count);
	assign dbit_in = dvd_q[SCALED_BITS-1];
	assign dvd_w   = DW_W'(dvd_q);
	assign dsat    = (dvd_w >= DIST_LIMIT);
	assign dprod   = PROD_W'(dvd_w[DX_W-1:0]) * PROD_W'(DM);
	assign lr      = {lrem_q, dbit_in};
	assign lge     = (lr >= {1'b0, div_q});

	always_comb begin
		result.kind                = kind_q;
		result.sensor              = sensor_q;
		result.distance_hundredths = dovf_q ? '1 : dq_q;
		result.level               = lovf_q ? '1 : lq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						if (q_hdr.kind == uer_pkg::KIND_TRIGGER) begin
							state_q <= B_OUT;
						end else begin
							state_q <= B_DIV;
							step_q  <= STEP_W'(SCALED_BITS - 1);
						end
					end
				end
				B_DIV: begin
					if (step_q == '0) begin
						state_q <= B_OUT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				B_OUT: begin
					if (result_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_hdr.kind;
			sensor_q <= q_hdr.sensor;
			dvd_q    <= scaled;
			div_q    <= (DIV_W'(full_hundredths) << 3) + (DIV_W'(full_hundredths) << 1);
			dq_q     <= '0;
			dovf_q   <= 1'b0;
			lrem_q   <= '0;
			lq_q     <= '0;
			lovf_q   <= 1'b0;
		end else if (state_q == B_DIV) begin
			if (step_q == STEP_W'(SCALED_BITS - 1)) begin
				dq_q   <= dprod[DM_S +: DIST_W];
				dovf_q <= dsat;
			end
			dvd_q  <= dvd_q << 1;
			lrem_q <= lge ? DIV_W'(lr - {1'b0, div_q}) : DIV_W'(lr);
			lovf_q <= lovf_q | lq_q[LEVEL_W-1];
			lq_q   <= {lq_q[LEVEL_W-2:0], lge};
		end
	end

	// divider runs its full count of steps
	`UER_ASSERT(a_div_hold, (state_q == B_DIV && step_q != '0) |=> (state_q == B_DIV), "divider left early")

endmodule

`default_nettype wire

// File: design/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// four-channel echo timer with distance and fill level results
// ----------------------------------------------------------------------------
// item beats (mode, channel) come in on a valid/ready channel; counter ticks,
// arming echo edges and unused modes give no result and are taken every
// cycle. a capturing echo edge or a trigger tick queues one job and is taken
// every cycle as long as the two-entry job queue has room.
// a trigger request passes through the job queue into the result register.
// a measurement runs a bit-serial level divider, one bit per cycle over
// COUNT_BITS+5 bits, and then lands in the result register; the back end
// holds one job at a time and pops the next one once the result is taken.
// when the result receiver stalls, the result register holds its beat, the
// queue fills and only beats that queue a job are held off; counter ticks
// keep being taken.
// reset clears the counter, armed flags, trigger pointer and queue, and loads
// count_period 65535 and full_hundredths 100. registers sit on an APB port,
// count_period at 0x0 and full_hundredths at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger #(
	parameter int CHANNELS   = uer_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire uer_pkg::in_beat_t                item,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	output uer_pkg::out_beat_t                    result,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [uer_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [uer_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	logic [uer_pkg::PERIOD_W-1:0] count_period_q;
	logic [uer_pkg::FULL_W-1:0]   full_q;
	logic                         reg_idx;
	logic                         cfg_wr;

	logic                    push;
	uer_pkg::job_hdr_t       push_hdr;
	logic [COUNT_BITS-1:0]   push_count;
	logic                    pop;
	uer_pkg::job_hdr_t       pop_hdr;
	logic [COUNT_BITS-1:0]   pop_count;
	logic                    q_empty;
	logic                    q_full;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_period_q <= uer_pkg::PERIOD_RESET;
			full_q         <= uer_pkg::FULL_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				uer_pkg::REG_COUNT_PERIOD: count_period_q <= pwdata[uer_pkg::PERIOD_W-1:0];
				uer_pkg::REG_FULL:         full_q         <= pwdata[uer_pkg::FULL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			uer_pkg::REG_COUNT_PERIOD: prdata = uer_pkg::CFG_DATA_W'(count_period_q);
			uer_pkg::REG_FULL:         prdata = uer_pkg::CFG_DATA_W'(full_q);
			default:                   prdata = '0;
		endcase
	end

	uer_front #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.count_period (count_period_q),
		.q_full       (q_full),
		.push         (push),
		.push_hdr     (push_hdr),
		.push_count   (push_count)
	);

	uer_queue #(
		.COUNT_BITS (COUNT_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_hdr   (push_hdr),
		.push_count (push_count),
		.pop        (pop),
		.pop_hdr    (pop_hdr),
		.pop_count  (pop_count),
		.empty      (q_empty),
		.full       (q_full)
	);

	uer_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_hdr           (pop_hdr),
		.q_count         (pop_count),
		.pop             (pop),
		.full_hundredths (full_q),
		.result          (result),
		.result_valid    (result_valid),
		.result_ready    (result_ready)
	);

endmodule

`default_nettype wire

// File: sim/echo_ranger_checker.sv
// ----------------------------------------------------------------------------
// echo_ranger_checker
// watches the item, result and register ports of the echo ranger, keeps its
// own copy of the counter, armed flags, trigger pointer and registers, and
// compares every result beat field by field with the oldest reading due
// ----------------------------------------------------------------------------

module echo_ranger_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  uer_pkg::in_beat_t                item,
	input  logic                             item_valid,
	input  logic                             item_ready,
	input  uer_pkg::out_beat_t               result,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [uer_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [uer_pkg::CFG_DATA_W-1:0]   pwdata,
	output int                               fail_count,
	output int                               readings_left
);
	timeunit 1ns;
	timeprecision 1ps;

	import uer_pkg::*;

	logic [PERIOD_W-1:0]       count_period;
	logic [FULL_W-1:0]         full_step;
	logic [COUNT_BITS_DEF-1:0] ticks;
	logic [CHANNELS_DEF-1:0]   open_chan;
	logic [SENSOR_W-1:0]       trig_ptr;
	out_beat_t                 readings_due[$];
	out_beat_t                 oldest;
	int                        fails;

	task automatic range_beat(input in_beat_t b);
		logic [31:0] scaled;
		logic [31:0] span;
		logic [31:0] lvl;
		out_beat_t   r;
		r = '0;
		case (b.mode)
			MODE_TICK: begin
				if (32'(ticks) >= 32'(count_period))
					ticks = '0;
				else
					ticks = ticks + 1'b1;
			end
			MODE_ECHO: begin
				if (int'(b.channel) < CHANNELS_DEF) begin
					if (!open_chan[b.channel]) begin
						ticks = '0;
						open_chan[b.channel] = 1'b1;
					end else begin
						open_chan[b.channel] = 1'b0;
						scaled = 32'(ticks) * 32'd17;
						span = scaled / 32'd10;
						if (span > 32'h1ffff)
							span = 32'h1ffff;
						if (full_step == '0) begin
							lvl = 32'd255;
						end else begin
							lvl = scaled / (32'd10 * 32'(full_step));
							if (lvl > 32'd255)
								lvl = 32'd255;
						end
						r.kind = KIND_MEASURE;
						r.sensor = b.channel;
						r.distance_hundredths = span[DIST_W-1:0];
						r.level = lvl[LEVEL_W-1:0];
						readings_due.push_back(r);
					end
				end
			end
			MODE_TRIGGER: begin
				r.kind = KIND_TRIGGER;
				r.sensor = trig_ptr;
				readings_due.push_back(r);
				trig_ptr = SENSOR_W'((int'(trig_ptr) + 1) % CHANNELS_DEF);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_period = PERIOD_RESET;
			full_step = FULL_RESET;
			ticks = '0;
			open_chan = '0;
			trig_ptr = '0;
			readings_due.delete();
			fails = 0;
			fail_count <= 0;
			readings_left <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_FULL)
					full_step = pwdata[FULL_W-1:0];
				else
					count_period = pwdata[PERIOD_W-1:0];
			end
			if (result_valid && result_ready) begin
				if (readings_due.size() == 0) begin
					$error("result beat with no reading due");
					fails++;
				end else begin
					oldest = readings_due.pop_front();
					check_field("kind", int'(oldest.kind), int'(result.kind));
					check_field("sensor", int'(oldest.sensor), int'(result.sensor));
					check_field("distance_hundredths", int'(oldest.distance_hundredths),
						int'(result.distance_hundredths));
					check_field("level", int'(oldest.level), int'(result.level));
				end
			end
			if (item_valid && item_ready)
				range_beat(item);
			fail_count <= fails;
			readings_left <= readings_due.size();
		end
	end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus for the ultrasonic echo ranger: a short directed part over trigger
// wrap, ignored modes, counter clearing and the register extremes, then three
// random phases of echo measurements with varied sender and receiver stalls,
// and one echo with the widest full step
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uer_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * (COUNT_BITS_DEF + 7);
	localparam int PHASE_ITEMS   = 270;
	localparam int PHASE_RUNS    = 20;

	logic                  clk;
	logic                  arst_n;
	in_beat_t              item;
	logic                  item_valid;
	logic                  item_ready;
	out_beat_t             result;
	logic                  result_valid;
	logic                  result_ready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int readings_left;
	int send_idle;
	int recv_idle;
	int beats_sent;
	int runs_done;
	bit chan_open[CHANNELS_DEF];

	ultrasonic_echo_ranger DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	echo_ranger_checker ranging_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.result        (result),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.readings_left (readings_left)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] channel);
		in_beat_t b;
		b.mode = mode;
		b.channel = channel;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (mode != MODE_UNUSED)
			beats_sent++;
		if (mode == MODE_ECHO)
			chan_open[channel] = !chan_open[channel];
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_beat(MODE_TICK, CHAN_W'($urandom_range(3)));
	endtask

	task automatic wait_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (readings_left != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// arm a channel, let ticks and noise pass, then usually capture it
	task automatic ranging_run();
		logic [CHAN_W-1:0] ch;
		bit                lengthy;
		int                steps;
		int                pick;
		ch = CHAN_W'($urandom_range(CHANNELS_DEF - 1));
		lengthy = ($urandom_range(99) < 25);
		steps = lengthy ? $urandom_range(12, 3) : $urandom_range(4, 0);
		send_beat(MODE_ECHO, ch);
		repeat (steps) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_ticks(lengthy ? $urandom_range(40) : $urandom_range(8));
			else if (pick < 85)
				send_beat(MODE_TRIGGER, CHAN_W'($urandom_range(3)));
			else if (pick < 93)
				send_beat(MODE_UNUSED, CHAN_W'($urandom_range(3)));
			else
				send_beat(MODE_ECHO, ch + CHAN_W'($urandom_range(3, 1)));
		end
		if ($urandom_range(99) < 92)
			send_beat(MODE_ECHO, ch);
		if ($urandom_range(99) < 3)
			wait_results();
	endtask

	initial begin
		arst_n = 1'b0;
		item = '0;
		item_valid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle = 27;
		recv_idle = 82;
		beats_sent = 0;
		runs_done = 0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// trigger pointer wrap and ignored modes
		for (int i = 0; i < 5; i++)
			send_beat(MODE_TRIGGER, CHAN_W'(i));
		wait_results();
		send_beat(MODE_UNUSED, 2'd3);
		send_beat(MODE_UNUSED, 2'd0);

		// capture at zero count, capture after ticks, shared counter cleared by another arm
		send_beat(MODE_ECHO, 2'd0);
		send_beat(MODE_ECHO, 2'd0);
		send_beat(MODE_ECHO, 2'd3);
		send_ticks(3);
		send_beat(MODE_TRIGGER, 2'd1);
		send_beat(MODE_ECHO, 2'd3);
		send_beat(MODE_ECHO, 2'd1);
		send_ticks(2);
		send_beat(MODE_ECHO, 2'd2);
		send_ticks(1);
		send_beat(MODE_ECHO, 2'd1);
		send_beat(MODE_ECHO, 2'd2);

		// zero period and zero full step
		settle();
		write_reg(REG_COUNT_PERIOD, 16'd0);
		write_reg(REG_FULL, 16'd0);
		send_beat(MODE_ECHO, 2'd0);
		send_ticks(2);
		send_beat(MODE_ECHO, 2'd0);

		// period lowered below the running count
		settle();
		write_reg(REG_COUNT_PERIOD, 16'hffff);
		write_reg(REG_FULL, 16'd1);
		send_beat(MODE_ECHO, 2'd2);
		send_ticks(20);
		settle();
		write_reg(REG_COUNT_PERIOD, 16'd5);
		send_ticks(2);
		send_beat(MODE_ECHO, 2'd2);

		for (int phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					send_idle = 27;
					recv_idle = 82;
					write_reg(REG_COUNT_PERIOD, 16'($urandom_range(600, 40)));
					write_reg(REG_FULL, 16'($urandom_range(20, 1)));
				end
				1: begin
					send_idle = 82;
					recv_idle = 27;
					write_reg(REG_COUNT_PERIOD, 16'($urandom_range(30, 1)));
					write_reg(REG_FULL, 16'($urandom_range(9, 2)));
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					write_reg(REG_COUNT_PERIOD, 16'hffff);
					write_reg(REG_FULL, 16'd1);
				end
			endcase
			beats_sent = 0;
			runs_done = 0;
			while (beats_sent < PHASE_ITEMS || runs_done < PHASE_RUNS) begin
				ranging_run();
				runs_done++;
			end
		end

		// widest full step
		settle();
		write_reg(REG_COUNT_PERIOD, 16'hffff);
		write_reg(REG_FULL, 16'hffff);
		if (chan_open[1])
			send_beat(MODE_ECHO, 2'd1);
		send_beat(MODE_ECHO, 2'd1);
		send_ticks(40);
		send_beat(MODE_ECHO, 2'd1);

		settle();
		if (fail_count == 0 && readings_left == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
